>>> design/fsrm_pkg.sv
`timescale 1ns / 1ps

package fsrm_pkg;

  // Built slot pool size
  localparam int MAX_SLOTS = 8;
  localparam int SlotIdxW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CntW      = $clog2(MAX_SLOTS + 1);

  // Fixed field widths
  localparam int KindW   = 3;
  localparam int SlotW   = 3;
  localparam int StatusW = 3;
  localparam int CfgW    = 4;
  localparam int PendW   = 4;

  localparam logic [CfgW-1:0] SLOT_COUNT_RST = CfgW'(3);

  typedef enum logic [1:0] {
    SS_AVAIL   = 2'd0,
    SS_WRITING = 2'd1,
    SS_PENDING = 2'd2,
    SS_READING = 2'd3
  } slot_state_e;

  typedef enum logic [KindW-1:0] {
    K_ACQUIRE    = 3'd0,
    K_WRITE_DONE = 3'd1,
    K_WRITE_FAIL = 3'd2,
    K_READ_REQ   = 3'd3,
    K_READ_DONE  = 3'd4,
    K_CLEAR      = 3'd5
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_GRANT      = 3'd0,
    ST_GRANT_DROP = 3'd1,
    ST_WAIT       = 3'd2,
    ST_READ_GIVEN = 3'd3,
    ST_NO_FRAME   = 3'd4,
    ST_ACK        = 3'd5
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;    // latch the incoming beat
    logic reduce;  // fold search start below active count
    logic drop;    // discard oldest pending frame
    logic commit;  // finish the event, load result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_acq;
    logic need_reduce;
    logic found;
    logic queue_empty;
  } sts_t;

endpackage

>>> design/fsrm_if.sv
`timescale 1ns / 1ps

// Event input channel
interface fsrm_evt_if;
  import fsrm_pkg::*;
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [SlotW-1:0] slot;
  modport source (output valid, kind, slot, input ready);
  modport sink   (input valid, kind, slot, output ready);
endinterface

// Slot count configuration channel
interface fsrm_cfg_if;
  import fsrm_pkg::*;
  logic            valid;
  logic            ready;
  logic [CfgW-1:0] slot_count;
  modport source (output valid, slot_count, input ready);
  modport sink   (input valid, slot_count, output ready);
endinterface

// Result output channel
interface fsrm_res_if;
  import fsrm_pkg::*;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [SlotW-1:0]   granted_slot;
  logic [SlotW-1:0]   dropped_slot;
  logic               snapshot_zeroed;
  logic [PendW-1:0]   frames_pending;
  logic               dirty;
  modport source (output valid, status, granted_slot, dropped_slot, snapshot_zeroed,
                  frames_pending, dirty, input ready);
  modport sink   (input valid, status, granted_slot, dropped_slot, snapshot_zeroed,
                  frames_pending, dirty, output ready);
endinterface

>>> design/fsrm_ctrl.sv
`timescale 1ns / 1ps

module fsrm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           evt_valid_i,
  output logic           evt_ready_o,
  input  logic           res_ready_i,
  output logic           res_valid_o,
  input  fsrm_pkg::sts_t sts_i,
  output fsrm_pkg::cmd_t cmd_o
);
  import fsrm_pkg::*;

  fsm_state_e state_q, state_d;
  logic       res_valid_q, res_valid_d;
  logic       out_free;

  assign out_free    = !res_valid_q || res_ready_i;
  assign res_valid_o = res_valid_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (evt_valid_i) state_d = FSM_EXEC;
      end
      FSM_EXEC: begin
        if (cmd_o.commit) state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    cmd_o       = '0;
    evt_ready_o = 1'b0;
    unique case (state_q)
      FSM_IDLE: begin
        evt_ready_o = 1'b1;
        cmd_o.load  = evt_valid_i;
      end
      FSM_EXEC: begin
        if (sts_i.is_acq && sts_i.need_reduce) begin
          cmd_o.reduce = 1'b1;
        end else if (sts_i.is_acq && !sts_i.found && !sts_i.queue_empty) begin
          cmd_o.drop = 1'b1;
        end else begin
          cmd_o.commit = out_free;
        end
      end
      default: ;
    endcase
  end

  // Result register occupancy
  always_comb begin
    res_valid_d = res_valid_q;
    if (cmd_o.commit)     res_valid_d = 1'b1;
    else if (res_ready_i) res_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

endmodule

>>> design/fsrm_datapath.sv
`timescale 1ns / 1ps

module fsrm_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  fsrm_pkg::cmd_t                 cmd_i,
  output fsrm_pkg::sts_t                 sts_o,
  input  logic [fsrm_pkg::KindW-1:0]     kind_i,
  input  logic [fsrm_pkg::SlotW-1:0]     slot_i,
  input  logic                           cfg_we_i,
  input  logic [fsrm_pkg::CfgW-1:0]      cfg_slot_count_i,
  output logic [fsrm_pkg::StatusW-1:0]   status_o,
  output logic [fsrm_pkg::SlotW-1:0]     granted_slot_o,
  output logic [fsrm_pkg::SlotW-1:0]     dropped_slot_o,
  output logic                           snapshot_zeroed_o,
  output logic [fsrm_pkg::PendW-1:0]     frames_pending_o,
  output logic                           dirty_o
);
  import fsrm_pkg::*;

  // Slot bookkeeping
  slot_state_e           state_q [MAX_SLOTS];
  slot_state_e           state_d [MAX_SLOTS];
  logic [SlotIdxW-1:0]   queue_q [MAX_SLOTS];
  logic [SlotIdxW-1:0]   head_q, head_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [SlotIdxW-1:0]   wp_q, wp_d;
  logic                  dirty_q, dirty_d;
  logic                  snap_q, snap_d;
  logic [CfgW-1:0]       cfg_q;

  // Current event
  logic [KindW-1:0]      kind_q, kind_d;
  logic [SlotW-1:0]      slot_q, slot_d;
  logic [SlotIdxW-1:0]   start_q, start_d;
  logic                  did_drop_q, did_drop_d;
  logic [SlotIdxW-1:0]   dropped_q, dropped_d;

  // Result register
  status_e               res_status_q, res_status_d;
  logic [SlotW-1:0]      res_granted_q, res_granted_d;
  logic [SlotW-1:0]      res_dropped_q, res_dropped_d;
  logic                  res_zeroed_q, res_zeroed_d;
  logic [PendW-1:0]      res_pending_q;
  logic                  res_dirty_q;

  logic [CntW-1:0]       n_act;
  logic [MAX_SLOTS-1:0]  avail, upper;
  logic [SlotIdxW-1:0]   up_idx, low_idx, pick;
  logic                  found;
  logic [CntW-1:0]       pick_nxt;
  logic [SlotIdxW-1:0]   pop_slot, head_nxt, tail;
  logic [CntW:0]         tail_sum;
  logic [SlotIdxW-1:0]   ev_slot;
  logic                  slot_ok;
  logic                  q_we;

  // Effective slot count, clamped to 1..MAX_SLOTS
  always_comb begin
    if (cfg_q == '0)                  n_act = CntW'(1);
    else if (int'(cfg_q) > MAX_SLOTS) n_act = CntW'(MAX_SLOTS);
    else                              n_act = CntW'(cfg_q);
  end

  // Round-robin search: first free slot at or after start, else first free below it
  always_comb begin
    up_idx  = '0;
    low_idx = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      avail[i] = (state_q[i] == SS_AVAIL) && (CntW'(i) < n_act);
      upper[i] = avail[i] && (SlotIdxW'(i) >= start_q);
    end
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (upper[i]) up_idx = SlotIdxW'(i);
      if (avail[i]) low_idx = SlotIdxW'(i);
    end
    found = |avail;
    pick  = (|upper) ? up_idx : low_idx;
  end

  assign pick_nxt = CntW'(pick) + CntW'(1);

  // Ready queue pointers
  assign pop_slot = queue_q[head_q];
  assign head_nxt = (int'(head_q) == MAX_SLOTS - 1) ? '0 : head_q + SlotIdxW'(1);
  assign tail_sum = (CntW + 1)'(head_q) + (CntW + 1)'(count_q);
  assign tail     = (int'(tail_sum) >= MAX_SLOTS)
                  ? SlotIdxW'(tail_sum - (CntW + 1)'(MAX_SLOTS))
                  : SlotIdxW'(tail_sum);

  assign ev_slot = slot_q[SlotIdxW-1:0];
  assign slot_ok = int'(slot_q) < MAX_SLOTS;

  // Status toward the controller
  always_comb begin
    sts_o.is_acq      = (kind_q == K_ACQUIRE);
    sts_o.need_reduce = (CntW'(start_q) >= n_act);
    sts_o.found       = found;
    sts_o.queue_empty = (count_q == '0);
  end

  // Event execution
  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    count_d       = count_q;
    wp_d          = wp_q;
    dirty_d       = dirty_q;
    snap_d        = snap_q;
    kind_d        = kind_q;
    slot_d        = slot_q;
    start_d       = start_q;
    did_drop_d    = did_drop_q;
    dropped_d     = dropped_q;
    q_we          = 1'b0;
    res_status_d  = ST_ACK;
    res_granted_d = '0;
    res_dropped_d = '0;
    res_zeroed_d  = 1'b0;

    if (cmd_i.load) begin
      kind_d     = kind_i;
      slot_d     = slot_i;
      start_d    = wp_q;
      did_drop_d = 1'b0;
      dropped_d  = '0;
    end

    if (cmd_i.reduce) start_d = start_q - SlotIdxW'(n_act);

    // Drop the oldest pending frame
    if (cmd_i.drop) begin
      state_d[pop_slot] = SS_AVAIL;
      head_d            = head_nxt;
      count_d           = count_q - CntW'(1);
      dirty_d           = (count_q != CntW'(1));
      did_drop_d        = 1'b1;
      dropped_d         = pop_slot;
    end

    if (cmd_i.commit) begin
      unique case (kind_q)
        K_ACQUIRE: begin
          if (found) begin
            state_d[pick] = SS_WRITING;
            wp_d          = (pick_nxt == n_act) ? '0 : SlotIdxW'(pick_nxt);
            res_granted_d = SlotW'(pick);
            if (did_drop_q) begin
              res_status_d  = ST_GRANT_DROP;
              res_dropped_d = SlotW'(dropped_q);
            end else begin
              res_status_d  = ST_GRANT;
            end
          end else begin
            res_status_d = ST_WAIT;
          end
        end
        K_WRITE_DONE: begin
          if (slot_ok && state_q[ev_slot] == SS_WRITING) begin
            state_d[ev_slot] = SS_PENDING;
            dirty_d          = 1'b1;
            if (int'(count_q) < MAX_SLOTS) begin
              q_we    = 1'b1;
              count_d = count_q + CntW'(1);
            end
          end
        end
        K_WRITE_FAIL: begin
          if (slot_ok && state_q[ev_slot] == SS_WRITING) state_d[ev_slot] = SS_AVAIL;
        end
        K_READ_REQ: begin
          res_status_d = ST_NO_FRAME;
          if (!dirty_q && snap_q) begin
            res_status_d = ST_NO_FRAME;
          end else if (count_q == '0) begin
            dirty_d = 1'b0;
            if (!snap_q) begin
              snap_d       = 1'b1;
              res_zeroed_d = 1'b1;
            end
          end else begin
            state_d[pop_slot] = SS_READING;
            head_d            = head_nxt;
            count_d           = count_q - CntW'(1);
            res_granted_d     = SlotW'(pop_slot);
            res_status_d      = ST_READ_GIVEN;
          end
        end
        K_READ_DONE: begin
          if (slot_ok && state_q[ev_slot] == SS_READING) begin
            state_d[ev_slot] = SS_AVAIL;
            snap_d           = 1'b1;
            dirty_d          = (count_q != '0);
          end
        end
        K_CLEAR: begin
          for (int i = 0; i < MAX_SLOTS; i++) state_d[i] = SS_AVAIL;
          head_d  = '0;
          count_d = '0;
          wp_d    = '0;
          snap_d  = 1'b0;
          dirty_d = 1'b1;
        end
        default: res_status_d = ST_ACK;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SLOTS; i++) state_q[i] <= SS_AVAIL;
      head_q     <= '0;
      count_q    <= '0;
      wp_q       <= '0;
      dirty_q    <= 1'b0;
      snap_q     <= 1'b1;
      cfg_q      <= SLOT_COUNT_RST;
      did_drop_q <= 1'b0;
    end else begin
      for (int i = 0; i < MAX_SLOTS; i++) state_q[i] <= state_d[i];
      head_q     <= head_d;
      count_q    <= count_d;
      wp_q       <= wp_d;
      dirty_q    <= dirty_d;
      snap_q     <= snap_d;
      did_drop_q <= did_drop_d;
      if (cfg_we_i) cfg_q <= cfg_slot_count_i;
    end
  end

  // Ready queue storage, appended at the tail
  always_ff @(posedge clk_i) begin
    if (q_we) queue_q[tail] <= ev_slot;
  end

  // Event and result payload
  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    slot_q    <= slot_d;
    start_q   <= start_d;
    dropped_q <= dropped_d;
    if (cmd_i.commit) begin
      res_status_q  <= res_status_d;
      res_granted_q <= res_granted_d;
      res_dropped_q <= res_dropped_d;
      res_zeroed_q  <= res_zeroed_d;
      res_pending_q <= PendW'(count_d);
      res_dirty_q   <= dirty_d;
    end
  end

  assign status_o          = res_status_q;
  assign granted_slot_o    = res_granted_q;
  assign dropped_slot_o    = res_dropped_q;
  assign snapshot_zeroed_o = res_zeroed_q;
  assign frames_pending_o  = res_pending_q;
  assign dirty_o           = res_dirty_q;

endmodule

>>> design/frame_slot_ring_manager_core.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake          Beat
// evt_i    in   valid/ready        kind, slot
// cfg_i    in   valid/ready (rdy=1) slot_count
// res_o    out  valid/ready        status, granted_slot, dropped_slot, snapshot_zeroed,
//                                  frames_pending, dirty
//
// One event at a time: the beat is latched while idle and finished in the execute state
// once the result register is free. An acquire first folds the search start below the
// slot count, then drops the oldest pending frame while no slot is free and frames wait.
// Reset leaves all slots available, the queue empty and the snapshot valid; no sweep.
// A result waiting on res_o does not block the next beat; only finishing it does.

module frame_slot_ring_manager_core (
  input logic        clk_i,
  input logic        rst_ni,
  fsrm_evt_if.sink   evt_i,
  fsrm_cfg_if.sink   cfg_i,
  fsrm_res_if.source res_o
);
  import fsrm_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic evt_ready;
  logic res_valid;

  assign cfg_i.ready = 1'b1;
  assign evt_i.ready = evt_ready;
  assign res_o.valid = res_valid;

  fsrm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_valid_i (evt_i.valid),
    .evt_ready_o (evt_ready),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fsrm_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .kind_i            (evt_i.kind),
    .slot_i            (evt_i.slot),
    .cfg_we_i          (cfg_i.valid),
    .cfg_slot_count_i  (cfg_i.slot_count),
    .status_o          (res_o.status),
    .granted_slot_o    (res_o.granted_slot),
    .dropped_slot_o    (res_o.dropped_slot),
    .snapshot_zeroed_o (res_o.snapshot_zeroed),
    .frames_pending_o  (res_o.frames_pending),
    .dirty_o           (res_o.dirty)
  );

  // Only one event in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_i.valid && evt_i.ready |=> !evt_i.ready)
    else $error("event accepted while another is in flight");

  // Queue occupancy never exceeds the pool
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> int'(res_o.frames_pending) <= MAX_SLOTS)
    else $error("frames_pending above pool size");

  // Dropped slot reported only with a grant after drop
  a_drop_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.status != StatusW'(ST_GRANT_DROP)) |-> res_o.dropped_slot == '0)
    else $error("dropped_slot set without a drop");

  // Blank frame only comes with a no-new-frame answer
  a_zeroed_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.snapshot_zeroed |-> res_o.status == StatusW'(ST_NO_FRAME))
    else $error("snapshot_zeroed with wrong status");

endmodule
